// ===== rtl/bba_pkg.sv =====
// shared constants and types for the bitmap block allocator
// depends on nothing; used by bba_mem, bba_ctrl and bitmap_block_allocator
package bba_pkg;

    localparam int NUM_BLOCKS = 4096;
    localparam int MAP_BYTES  = (NUM_BLOCKS + 7) / 8;
    localparam int ADDR_W     = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
    localparam int LAST_VALID = NUM_BLOCKS - 8 * (MAP_BYTES - 1);

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAP_BYTES - 1);
    // bits of the last byte past the end of the map read as used
    localparam logic [7:0] SPARE_MASK = 8'(8'hFF >> LAST_VALID);
    localparam logic [7:0] FULL_BYTE  = 8'hFF;
    localparam logic [7:0] TOP_BIT    = 8'h80;

    localparam logic [1:0] MODE_FIND   = 2'd0;
    localparam logic [1:0] MODE_TOGGLE = 2'd1;
    localparam logic [1:0] MODE_SET    = 2'd2;
    localparam logic [1:0] MODE_CLEAR  = 2'd3;

    typedef logic [ADDR_W-1:0] t_addr;

    typedef struct packed {
        logic [11:0] free_index;
        logic        none_free;
    } t_result;

    typedef struct packed {
        logic       rd_en;
        t_addr      rd_addr;
        logic       wr_en;
        t_addr      wr_addr;
        logic [7:0] wr_data;
    } t_mem_req;

endpackage

// ===== rtl/bba_req_if.sv =====
// request channel of the bitmap block allocator
// depends on nothing
interface bba_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [11:0] block_index;

    modport source (output valid, output mode, output block_index, input ready);
    modport sink   (input valid, input mode, input block_index, output ready);
endinterface

// ===== rtl/bba_rsp_if.sv =====
// response channel of the bitmap block allocator
// depends on nothing
interface bba_rsp_if;
    logic        valid;
    logic        ready;
    logic [11:0] free_index;
    logic        none_free;

    modport source (output valid, output free_index, output none_free, input ready);
    modport sink   (input valid, input free_index, input none_free, output ready);
endinterface

// ===== rtl/bba_mem.sv =====
// bitmap storage: one byte per entry, one write and one registered read port
// depends on bba_pkg
module bba_mem (
    input  logic              i_clk,
    input  bba_pkg::t_mem_req i_req,
    output logic [7:0]        o_rd_data
);

    logic [7:0] r_mem [bba_pkg::MAP_BYTES];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/bba_ctrl.sv =====
// sequencer: clearing pass, read-modify-write of one byte, byte-serial find
// depends on bba_pkg and bba_req_if
module bba_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    bba_req_if.sink            i_req,
    output bba_pkg::t_mem_req  o_mem,
    input  logic [7:0]         i_rd_data,
    output logic               o_res_valid,
    output bba_pkg::t_result   o_res,
    input  logic               i_res_ready
);

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_MOD  = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_RESP = 3'd4;

    logic [2:0]       r_state, n_state;
    bba_pkg::t_addr   r_addr, n_addr;
    logic [1:0]       r_mode, n_mode;
    logic [7:0]       r_mask, n_mask;
    bba_pkg::t_result r_res, n_res;

    logic [7:0]     scan_byte;
    logic           zero_hit;
    logic [2:0]     zero_bit;
    logic [11:0]    found_num;
    logic           in_range;
    bba_pkg::t_addr req_addr;

    assign in_range = 32'(i_req.block_index) < 32'(bba_pkg::NUM_BLOCKS);
    assign req_addr = bba_pkg::t_addr'(i_req.block_index[11:3]);

    // lowest block in a byte sits at the msb
    always_comb begin
        scan_byte = i_rd_data | ((r_addr == bba_pkg::LAST_ADDR) ? bba_pkg::SPARE_MASK : 8'h00);
        zero_hit  = 1'b0;
        zero_bit  = 3'd0;
        for (int b = 0; b < 8; b++) begin
            if (!zero_hit && !scan_byte[7 - b]) begin
                zero_hit = 1'b1;
                zero_bit = 3'(b);
            end
        end
        found_num = 12'(32'(r_addr) * 32'd8 + 32'(zero_bit));
    end

    always_comb begin
        n_state       = r_state;
        n_addr        = r_addr;
        n_mode        = r_mode;
        n_mask        = r_mask;
        n_res         = r_res;
        o_mem.rd_en   = 1'b0;
        o_mem.rd_addr = r_addr;
        o_mem.wr_en   = 1'b0;
        o_mem.wr_addr = r_addr;
        o_mem.wr_data = 8'h00;
        o_res_valid   = 1'b0;
        i_req.ready   = 1'b0;

        unique case (r_state)
            S_CLR: begin
                o_mem.wr_en = 1'b1;
                if (r_addr == bba_pkg::LAST_ADDR) begin
                    n_addr  = '0;
                    n_state = S_IDLE;
                end else begin
                    n_addr = r_addr + bba_pkg::t_addr'(1);
                end
            end
            S_IDLE: begin
                i_req.ready = 1'b1;
                if (i_req.valid) begin
                    n_mode = i_req.mode;
                    n_mask = bba_pkg::TOP_BIT >> i_req.block_index[2:0];
                    n_res  = '0;
                    if (i_req.mode == bba_pkg::MODE_FIND) begin
                        o_mem.rd_en   = 1'b1;
                        o_mem.rd_addr = '0;
                        n_addr        = '0;
                        n_state       = S_SCAN;
                    end else if (in_range) begin
                        o_mem.rd_en   = 1'b1;
                        o_mem.rd_addr = req_addr;
                        n_addr        = req_addr;
                        n_state       = S_MOD;
                    end else begin
                        n_state = S_RESP;
                    end
                end
            end
            S_MOD: begin
                o_mem.wr_en = 1'b1;
                case (r_mode)
                    bba_pkg::MODE_TOGGLE: o_mem.wr_data = i_rd_data ^ r_mask;
                    bba_pkg::MODE_SET:    o_mem.wr_data = i_rd_data | r_mask;
                    default:              o_mem.wr_data = i_rd_data & ~r_mask;
                endcase
                n_state = S_RESP;
            end
            S_SCAN: begin
                if (scan_byte != bba_pkg::FULL_BYTE && zero_hit) begin
                    n_res.free_index = found_num;
                    n_res.none_free  = 1'b0;
                    n_state          = S_RESP;
                end else if (r_addr == bba_pkg::LAST_ADDR) begin
                    n_res.free_index = 12'd0;
                    n_res.none_free  = 1'b1;
                    n_state          = S_RESP;
                end else begin
                    // fetch the next byte while this one is checked
                    o_mem.rd_en   = 1'b1;
                    o_mem.rd_addr = r_addr + bba_pkg::t_addr'(1);
                    n_addr        = r_addr + bba_pkg::t_addr'(1);
                end
            end
            S_RESP: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_addr  <= '0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode <= n_mode;
        r_mask <= n_mask;
        r_res  <= n_res;
    end

    assign o_res = r_res;

endmodule

// ===== rtl/bitmap_block_allocator.sv =====
// channel   dir  handshake    payload
// i_req     in   valid/ready  mode[1:0], block_index[11:0]
// o_rsp     out  valid/ready  free_index[11:0], none_free
//
// one item at a time through a single byte-wide bitmap memory (registered read)
// set/toggle/clear: read, write back, hand off; out of range: hand off only
// find: reads bytes in order up to the first byte that is not full (max 512), then hands off
// after reset a clearing pass writes all 512 bytes to zero, with i_req.ready low
// the result sits in an output register, so the next item is taken while it waits
// depends on bba_pkg, bba_req_if, bba_rsp_if, bba_mem, bba_ctrl
module bitmap_block_allocator (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bba_req_if.sink   i_req,
    bba_rsp_if.source o_rsp
);

    bba_pkg::t_mem_req mem_req;
    logic [7:0]        rd_data;
    logic              res_valid;
    logic              res_ready;
    bba_pkg::t_result  res;

    logic              r_out_valid;
    bba_pkg::t_result  r_out;

    bba_mem u_mem (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

    bba_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_mem       (mem_req),
        .i_rd_data   (rd_data),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (res_ready)
    );

    assign res_ready = !r_out_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.free_index = r_out.free_index;
    assign o_rsp.none_free  = r_out.none_free;

endmodule
